/* rtl/mfdm_pkg.sv */
// Package for the fade and duck mixer: item types, codes, constants and arithmetic helpers.
// No dependencies.
package mfdm_pkg;

    localparam int CHANNELS    = 32;
    localparam int GROUP_SPLIT = 16;
    localparam int CH_W        = $clog2(CHANNELS);

    localparam logic [2:0] FUNC_TICK      = 3'd0;
    localparam logic [2:0] FUNC_FO_PAUSE  = 3'd1;
    localparam logic [2:0] FUNC_FO_STOP   = 3'd2;
    localparam logic [2:0] FUNC_FADEIN    = 3'd3;
    localparam logic [2:0] FUNC_EV_TOGGLE = 3'd4;
    localparam logic [2:0] FUNC_EV_RESET  = 3'd5;
    localparam logic [2:0] FUNC_EV_ALT    = 3'd6;
    localparam logic [2:0] FUNC_NONE      = 3'd7;

    localparam logic [16:0] FULL_SCALE = 17'h10000;
    localparam logic [14:0] VOICE_MAX  = 15'h6000;
    localparam logic [14:0] VOICE_UP   = 15'h00F5;
    localparam logic [14:0] VOICE_DOWN = 15'h007A;
    localparam logic [14:0] VIEW_MAX   = 15'h5000;
    localparam logic [14:0] VIEW_UP    = 15'h00CC;
    localparam logic [14:0] VIEW_DOWN  = 15'h0066;
    localparam logic [16:0] FADER_TOP  = 17'h0FFFF;

    localparam logic [CHANNELS-1:0] ALL_DONE = '1;

    localparam logic [0:0] ADDR_DUCK_EXEMPT = 1'b0;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] fade_rate;
        logic        stream_active;
        logic        first_person;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  channel;
        logic [16:0] volume;
        logic        last;
        logic        all_faded;
        logic        song_finished;
    } out_item_t;

    // Signed truncating division of a 17-bit difference by one of the fader divisors.
    // The magnitude is below 2^16, so a reciprocal multiply and shift is exact.
    function automatic logic [16:0] div_step(input logic signed [17:0] d,
                                             input logic [10:0] k);
        logic [17:0] mag;
        logic [16:0] m;
        logic [4:0]  s;
        logic [34:0] p;
        logic [16:0] q;
        begin
            mag = d[17] ? 18'(-d) : 18'(d);
            case (k)
                11'd100:
                begin
                    m = 17'd83887;
                    s = 5'd23;
                end
                11'd400:
                begin
                    m = 17'd83887;
                    s = 5'd25;
                end
                11'd1000:
                begin
                    m = 17'd67109;
                    s = 5'd26;
                end
                default:
                begin
                    m = 17'd111849;
                    s = 5'd27;
                end
            endcase
            p = 35'(mag[15:0]) * 35'(m);
            q = 17'(p >> s);
            div_step = d[17] ? 17'(-q) : q;
        end
    endfunction

endpackage

/* rtl/mfdm_front.sv */
// Front part: accepts items and turns them into a queued command.
// Depends on mfdm_pkg.
module mfdm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  mfdm_pkg::in_item_t  in_item,
    input  logic                in_valid,
    output logic                in_stall,
    output mfdm_pkg::in_item_t  q_item,
    output logic                q_valid,
    input  logic                q_pop
);
    import mfdm_pkg::*;

    // Two-entry queue
    in_item_t   mem_reg [2];
    logic [0:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall && (in_item.func != FUNC_NONE);
    assign pop      = q_pop && (cnt_reg != 2'd0);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop) else $error("queue underflow");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("bad count");
`endif

endmodule

/* rtl/mfdm_back.sv */
// Back part: executes commands, walks the channels on a tick, emits volumes.
// Depends on mfdm_pkg.
module mfdm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mfdm_pkg::in_item_t  q_item,
    input  logic                q_valid,
    output logic                q_pop,
    input  logic [31:0]         exempt_mask,
    output mfdm_pkg::out_item_t out_item,
    output logic                out_valid,
    input  logic                out_stall
);
    import mfdm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMD  = 3'd1;
    localparam logic [2:0] ST_TFAD = 3'd2;
    localparam logic [2:0] ST_TGLB = 3'd3;
    localparam logic [2:0] ST_TCH  = 3'd4;
    localparam logic [2:0] ST_TMUL = 3'd5;
    localparam logic [2:0] ST_TOUT = 3'd6;

    // Per-channel stores
    logic [15:0] fspd_reg  [CHANNELS];
    logic [16:0] flev_reg  [CHANNELS];
    logic [16:0] fdl_reg   [CHANNELS];
    logic [16:0] fdg_reg   [CHANNELS];
    logic [16:0] fds_reg   [CHANNELS];

    logic [CHANNELS-1:0] done_reg;
    logic [15:0] fin_reg;
    logic [14:0] voice_reg, view_reg;
    logic        ev_reg, stop_reg, paused_reg, fin_flag_reg;
    logic [2:0]  st_reg;
    logic [CH_W-1:0] ch_reg;
    in_item_t    cmd_reg;
    logic        any_reg, left_reg;
    logic [33:0] prod_reg;
    out_item_t   out_reg;
    logic        ov_reg;

    logic [15:0] rate;
    logic [16:0] duck;
    logic [16:0] worst;
    logic [16:0] nl;
    logic [16:0] lv, gl, sp;
    logic [16:0] vol_calc;
    logic [17:0] fsum;
    logic        hi;

    assign rate      = (q_item.fade_rate == 16'd0) ? 16'd1 : q_item.fade_rate;
    assign q_pop     = (st_reg == ST_IDLE) && q_valid;
    assign out_item  = out_reg;
    assign out_valid = ov_reg;

    // Fader step, duck level, volume and fade sum for the current channel
    always_comb
    begin
        lv = fdl_reg[ch_reg];
        gl = fdg_reg[ch_reg];
        sp = fds_reg[ch_reg];
        nl = lv;
        if (lv != gl)
        begin
            nl = lv + sp;
            if (!sp[16])
            begin
                if ($signed(nl) > $signed(gl))
                    nl = gl;
            end
            else if ($signed(nl) < $signed(gl))
            begin
                nl = gl;
            end
        end
        if (view_reg >= voice_reg && !exempt_mask[ch_reg])
            duck = 17'(view_reg);
        else
            duck = 17'(voice_reg);
        worst    = (flev_reg[ch_reg] > duck) ? flev_reg[ch_reg] : duck;
        vol_calc = (worst > FULL_SCALE) ? 17'd0 : FULL_SCALE - worst;
        fsum     = 18'(flev_reg[ch_reg]) + 18'(fspd_reg[ch_reg]);
        hi       = ((32'(ch_reg) < GROUP_SPLIT) == (cmd_reg.func == FUNC_EV_RESET));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                fspd_reg[i] <= '0;
                flev_reg[i] <= '0;
                fdl_reg[i]  <= FADER_TOP;
                fdg_reg[i]  <= FADER_TOP;
                fds_reg[i]  <= '0;
            end
            done_reg     <= '0;
            fin_reg      <= '0;
            voice_reg    <= '0;
            view_reg     <= '0;
            ev_reg       <= 1'b0;
            stop_reg     <= 1'b0;
            paused_reg   <= 1'b0;
            fin_flag_reg <= 1'b0;
            st_reg       <= ST_IDLE;
            ch_reg       <= '0;
            cmd_reg      <= '0;
            any_reg      <= 1'b0;
            left_reg     <= 1'b0;
            prod_reg     <= '0;
            out_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            // Drop the result once taken, unless the output state reloads it
            if (ov_reg && !out_stall && st_reg != ST_TOUT)
                ov_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_item;
                        ch_reg  <= '0;
                        any_reg <= 1'b0;
                        left_reg <= 1'b0;
                        st_reg  <= (q_item.func == FUNC_TICK) ? ST_TFAD :
                                   (q_item.func == FUNC_EV_TOGGLE ||
                                    q_item.func == FUNC_EV_RESET ||
                                    q_item.func == FUNC_EV_ALT) ? ST_CMD : ST_IDLE;
                        if (q_item.func == FUNC_FO_PAUSE || q_item.func == FUNC_FO_STOP)
                        begin
                            if (done_reg != ALL_DONE ||
                                (q_item.func == FUNC_FO_STOP && fin_reg != 16'd0))
                            begin
                                for (int i = 0; i < CHANNELS; i++)
                                    if (!done_reg[i])
                                        fspd_reg[i] <= rate;
                            end
                            fin_reg <= (done_reg != ALL_DONE ||
                                q_item.func == FUNC_FO_STOP) ? 16'd0 : fin_reg;
                            if (q_item.func == FUNC_FO_STOP)
                                stop_reg <= 1'b1;
                        end
                        else if (q_item.func == FUNC_FADEIN)
                        begin
                            if (!stop_reg)
                            begin
                                paused_reg <= 1'b0;
                                fin_reg    <= rate;
                                for (int i = 0; i < CHANNELS; i++)
                                    fspd_reg[i] <= '0;
                                done_reg <= '0;
                                ev_reg   <= 1'b0;
                            end
                        end
                    end
                end
                ST_CMD:
                begin
                    // One channel per cycle for evasion commands
                    if (cmd_reg.func == FUNC_EV_TOGGLE)
                    begin
                        if (!ev_reg)
                        begin
                            if (32'(ch_reg) < GROUP_SPLIT)
                            begin
                                fdg_reg[ch_reg] <= '0;
                                fds_reg[ch_reg] <= div_step(-$signed(18'(lv)), 11'd1200);
                            end
                            else
                            begin
                                fdg_reg[ch_reg] <= FADER_TOP;
                                fds_reg[ch_reg] <= div_step($signed(18'(FADER_TOP)) -
                                    $signed(18'(lv)), 11'd1000);
                            end
                        end
                        else
                        begin
                            if (32'(ch_reg) < GROUP_SPLIT)
                            begin
                                fdg_reg[ch_reg] <= FADER_TOP;
                                fds_reg[ch_reg] <= div_step($signed(18'(FADER_TOP)) -
                                    $signed(18'(lv)), 11'd100);
                            end
                            else
                            begin
                                fdg_reg[ch_reg] <= '0;
                                fds_reg[ch_reg] <= div_step(-$signed(18'(lv)), 11'd400);
                            end
                        end
                    end
                    else
                    begin
                        fdl_reg[ch_reg] <= hi ? FADER_TOP : 17'd0;
                        fdg_reg[ch_reg] <= hi ? FADER_TOP : 17'd0;
                        fds_reg[ch_reg] <= '0;
                    end
                    if (32'(ch_reg) == CHANNELS - 1)
                    begin
                        ev_reg <= (cmd_reg.func == FUNC_EV_TOGGLE) ? !ev_reg : 1'b0;
                        st_reg <= ST_IDLE;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_TFAD:
                begin
                    // Sweep the fade speeds: note whether any channel is fading out
                    if (fspd_reg[ch_reg] != 16'd0)
                        any_reg <= 1'b1;
                    if (32'(ch_reg) == CHANNELS - 1)
                    begin
                        ch_reg <= '0;
                        st_reg <= ST_TGLB;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_TGLB:
                begin
                    // Walk channels again to apply fade arithmetic
                    if (any_reg)
                    begin
                        if (fspd_reg[ch_reg] != 16'd0)
                        begin
                            if (fsum >= 18'(FULL_SCALE))
                            begin
                                flev_reg[ch_reg] <= FULL_SCALE;
                                fspd_reg[ch_reg] <= '0;
                                done_reg[ch_reg] <= 1'b1;
                            end
                            else
                            begin
                                flev_reg[ch_reg] <= fsum[16:0];
                            end
                        end
                    end
                    else if (fin_reg != 16'd0)
                    begin
                        if (flev_reg[ch_reg] <= 17'(fin_reg))
                            flev_reg[ch_reg] <= '0;
                        else
                        begin
                            flev_reg[ch_reg] <= flev_reg[ch_reg] - 17'(fin_reg);
                            left_reg <= 1'b1;
                        end
                    end
                    if (32'(ch_reg) == CHANNELS - 1)
                    begin
                        ch_reg <= '0;
                        st_reg <= ST_TCH;
                        fin_flag_reg <= 1'b0;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_TCH:
                begin
                    // Global updates once, before the output walk
                    if (any_reg)
                    begin
                        if (done_reg == ALL_DONE)
                        begin
                            if (!stop_reg)
                                paused_reg <= 1'b1;
                        end
                        else
                        begin
                            paused_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        if (cmd_reg.stream_active)
                        begin
                            if (voice_reg < VOICE_MAX)
                                voice_reg <= (voice_reg + VOICE_UP > VOICE_MAX) ?
                                    VOICE_MAX : voice_reg + VOICE_UP;
                        end
                        else if (voice_reg != 15'd0)
                        begin
                            voice_reg <= (voice_reg < VOICE_DOWN) ? 15'd0 :
                                voice_reg - VOICE_DOWN;
                        end
                        if (fin_reg != 16'd0 && !left_reg)
                            fin_reg <= '0;
                    end
                    if (stop_reg && done_reg == ALL_DONE)
                    begin
                        fin_flag_reg <= 1'b1;
                        stop_reg     <= 1'b0;
                    end
                    if (cmd_reg.first_person)
                    begin
                        if (view_reg < VIEW_MAX)
                            view_reg <= (view_reg + VIEW_UP > VIEW_MAX) ?
                                VIEW_MAX : view_reg + VIEW_UP;
                    end
                    else if (view_reg != 15'd0)
                    begin
                        view_reg <= (view_reg < VIEW_DOWN) ? 15'd0 : view_reg - VIEW_DOWN;
                    end
                    st_reg <= ST_TMUL;
                    cmd_reg.func <= FUNC_NONE;
                end
                ST_TMUL:
                begin
                    // Attenuation and fader step, then multiply
                    if (cmd_reg.func == FUNC_NONE)
                    begin
                        fdl_reg[ch_reg] <= nl;
                        if (nl == gl && lv != gl && nl != lv + sp)
                            fds_reg[ch_reg] <= '0;
                        prod_reg <= 34'(vol_calc) * 34'(nl[15:0]) +
                            (nl[16] ? 34'(vol_calc) << 16 : 34'd0);
                        cmd_reg.func <= FUNC_TICK;
                    end
                    else
                    begin
                        st_reg <= ST_TOUT;
                    end
                end
                default:
                begin
                    // Divide by 65535 and hand over
                    if (!ov_reg || !out_stall)
                    begin
                        out_reg.channel <= 5'(ch_reg);
                        out_reg.volume  <= 17'((prod_reg + (prod_reg >> 16) + 34'd1) >> 16);
                        out_reg.last    <= (32'(ch_reg) == CHANNELS - 1);
                        out_reg.all_faded     <= paused_reg;
                        out_reg.song_finished <= fin_flag_reg;
                        ov_reg <= 1'b1;
                        if (32'(ch_reg) == CHANNELS - 1)
                            st_reg <= ST_IDLE;
                        else
                        begin
                            ch_reg <= ch_reg + 1'b1;
                            cmd_reg.func <= FUNC_NONE;
                            st_reg <= ST_TMUL;
                        end
                    end
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg) else $error("result dropped");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == ST_IDLE) else $error("pop while busy");
    a_voice: assert property (@(posedge clk) disable iff (!rst_n)
        voice_reg <= VOICE_MAX) else $error("voice duck out of range");
`endif

endmodule

/* rtl/multichannel_fade_duck_mixer.sv */
// Top level of the fade and duck mixer: APB register, front queue and back engine.
// Depends on mfdm_pkg, mfdm_front, mfdm_back.
//
//  channel | direction | payload      | handshake
//  in      | input     | in_item_t    | in_valid / in_stall
//  out     | output    | out_item_t   | out_valid / out_stall
//  apb     | input     | duck mask    | psel / penable / pwrite
//
// A tick leaves the queue, sweeps the fade speeds over all channels, updates the fade
// levels, updates the ramps once and then walks the channels to output their volumes.
// Evasion commands walk the channels once; fade commands finish as they leave the queue.
// Reset clears all state but the queue storage at once; no clearing pass is needed.
// A stalled output holds the walk; the front queue keeps taking items until it is full.
module multichannel_fade_duck_mixer (
    input  logic                clk,
    input  logic                rst_n,
    input  mfdm_pkg::in_item_t  in_item,
    input  logic                in_valid,
    output logic                in_stall,
    output mfdm_pkg::out_item_t out_item,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [0:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mfdm_pkg::*;

    logic [31:0] mask_reg;
    in_item_t    q_item;
    logic        q_valid, q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DUCK_EXEMPT) ? mask_reg : 32'd0;

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else if (psel && penable && pwrite && paddr == ADDR_DUCK_EXEMPT)
            mask_reg <= pwdata;
    end

    mfdm_front u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .in_valid(in_valid),
        .in_stall(in_stall), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
    );

    mfdm_back u_back (
        .clk(clk), .rst_n(rst_n), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
        .exempt_mask(mask_reg), .out_item(out_item), .out_valid(out_valid),
        .out_stall(out_stall)
    );

endmodule
